[hw/rtl/macd_indicator_unit_macros.svh]
// assertion macros shared by the macd indicator unit
// expects clk and rst_n in the scope of use
`ifndef MACD_INDICATOR_UNIT_MACROS_SVH
`define MACD_INDICATOR_UNIT_MACROS_SVH

// same-cycle implication
`define MACD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MACD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/macd_pkg.sv]
// shared constants, types and helper functions of the macd indicator unit
// no dependencies
package macd_pkg;

  localparam int PRICE_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int PERIOD_W   = 8;
  localparam int OUT_W      = PRICE_W + 2;
  localparam int ALPHA_W    = FRAC_W + 1;
  localparam int SEED_W     = PRICE_W + PERIOD_W;
  localparam int SIG_SEED_W = SEED_W + 2;
  localparam int COUNT_W    = PERIOD_W + 1;
  localparam int AVG_W      = SIG_SEED_W + 1;
  localparam int DIFF_W     = AVG_W + 1;
  localparam int PROD_W     = DIFF_W + ALPHA_W + 1;
  localparam int DIV_W      = SIG_SEED_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (ALPHA_W > PERIOD_W) ? ALPHA_W : PERIOD_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_PERIOD = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_ALPHA    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ALPHA    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_ALPHA  = CFG_IDX_W'(5);

  localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST   = PERIOD_W'(12);
  localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST   = PERIOD_W'(26);
  localparam logic [PERIOD_W-1:0] SIGNAL_PERIOD_RST = PERIOD_W'(9);
  localparam logic [ALPHA_W-1:0]  FAST_ALPHA_RST    = ALPHA_W'(10082);
  localparam logic [ALPHA_W-1:0]  SLOW_ALPHA_RST    = ALPHA_W'(4855);
  localparam logic [ALPHA_W-1:0]  SIGNAL_ALPHA_RST  = ALPHA_W'(13107);

  typedef enum logic [1:0] {
    DIV_FAST,
    DIV_SLOW,
    DIV_SIG
  } macd_div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRICE,
    ST_EMA,
    ST_FWAIT,
    ST_SWAIT,
    ST_MACD,
    ST_SIG,
    ST_SEMA,
    ST_GWAIT,
    ST_OUT
  } macd_state_t;

  typedef struct packed {
    logic          load;
    logic          price_stage;
    logic          ema_stage;
    logic          macd_stage;
    logic          sig_stage;
    logic          sema_stage;
    logic          out_load;
    logic          div_start;
    macd_div_sel_t div_sel;
    logic          wr_fast;
    logic          wr_slow;
    logic          wr_sig;
  } macd_cmd_t;

  typedef struct packed {
    logic fast_div;
    logic slow_div;
    logic macd_ok;
    logic sig_div;
    logic div_done;
  } macd_stat_t;

  function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] p);
    return (p == '0) ? PERIOD_W'(1) : p;
  endfunction

  // anything above one acts as one
  function automatic logic [ALPHA_W-1:0] eff_alpha(input logic [ALPHA_W-1:0] a);
    return a[ALPHA_W-1] ? {1'b1, {(ALPHA_W-1){1'b0}}} : a;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-OUT_W:0] hi_bits;
    hi_bits = v[DIFF_W-1:OUT_W-1];
    if (hi_bits == '0 || hi_bits == '1) begin
      return v[OUT_W-1:0];
    end else if (v[DIFF_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

[hw/rtl/macd_if.sv]
// word channels of the macd indicator unit: price input and result output
// depends on macd_pkg
interface macd_in_if;
  logic                         valid;
  logic                         ready;
  logic [macd_pkg::PRICE_W-1:0] price;
  logic                         restart;

  modport source (output valid, output price, output restart, input ready);
  modport sink (input valid, input price, input restart, output ready);
endinterface

interface macd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [macd_pkg::OUT_W-1:0] macd_value;
  logic signed [macd_pkg::OUT_W-1:0] signal_value;
  logic signed [macd_pkg::OUT_W-1:0] histogram_value;
  logic                              macd_valid;
  logic                              signal_valid;

  modport source (output valid, output macd_value, output signal_value,
                  output histogram_value, output macd_valid, output signal_valid,
                  input ready);
  modport sink (input valid, input macd_value, input signal_value,
                input histogram_value, input macd_valid, input signal_valid,
                output ready);
endinterface

[hw/rtl/macd_divider.sv]
// unsigned restoring divider, one quotient bit per cycle
// depends on macd_pkg
module macd_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [macd_pkg::DIV_W-1:0]    dividend,
  input  logic [macd_pkg::PERIOD_W-1:0] divisor,
  output logic                          done,
  output logic [macd_pkg::DIV_W-1:0]    quotient
);

  logic [macd_pkg::DIV_W-1:0]     quo_r, quo_nxt;
  logic [macd_pkg::PERIOD_W-1:0]  rem_r, rem_nxt;
  logic [macd_pkg::PERIOD_W-1:0]  dvs_r, dvs_nxt;
  logic [macd_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [macd_pkg::PERIOD_W:0]    shifted;
  logic [macd_pkg::PERIOD_W:0]    trial;
  logic                           ge;

  assign shifted = {rem_r, quo_r[macd_pkg::DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[macd_pkg::DIV_W-2:0], ge};
      rem_nxt = ge ? trial[macd_pkg::PERIOD_W-1:0] : shifted[macd_pkg::PERIOD_W-1:0];
      cnt_nxt = cnt_r + macd_pkg::DIV_CNT_W'(1);
      if (cnt_r == macd_pkg::DIV_CNT_W'(macd_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hw/rtl/macd_datapath.sv]
// macd datapath: configuration registers, averages, seed sums, multipliers,
// seed divider and result register; depends on macd_pkg and macd_divider
module macd_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [macd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [macd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [macd_pkg::PRICE_W-1:0]         in_price,
  input  logic                                 in_restart,
  input  macd_pkg::macd_cmd_t                  cmd,
  output macd_pkg::macd_stat_t                 stat,
  output logic signed [macd_pkg::OUT_W-1:0]    res_macd,
  output logic signed [macd_pkg::OUT_W-1:0]    res_signal,
  output logic signed [macd_pkg::OUT_W-1:0]    res_hist,
  output logic                                 res_macd_ok,
  output logic                                 res_sig_ok
);

  localparam int PW  = macd_pkg::PERIOD_W;
  localparam int AW  = macd_pkg::ALPHA_W;
  localparam int CW  = macd_pkg::COUNT_W;
  localparam int VW  = macd_pkg::AVG_W;
  localparam int DW  = macd_pkg::DIFF_W;
  localparam int OW  = macd_pkg::OUT_W;
  localparam int SW  = macd_pkg::SEED_W;
  localparam int GW  = macd_pkg::SIG_SEED_W;
  localparam int XW  = macd_pkg::PRICE_W;
  localparam int MW  = macd_pkg::PROD_W;
  localparam int QW  = macd_pkg::DIV_W;

  // configuration
  logic [PW-1:0] fast_period_r, slow_period_r, signal_period_r;
  logic [AW-1:0] fast_alpha_r, slow_alpha_r, signal_alpha_r;

  // series state
  logic [CW-1:0]        sample_count_r, sample_count_nxt;
  logic [CW-1:0]        macd_count_r, macd_count_nxt;
  logic signed [VW-1:0] fast_avg_r, fast_avg_nxt;
  logic signed [VW-1:0] slow_avg_r, slow_avg_nxt;
  logic signed [VW-1:0] sig_avg_r, sig_avg_nxt;
  logic [SW-1:0]        fast_sum_r, fast_sum_nxt;
  logic [SW-1:0]        slow_sum_r, slow_sum_nxt;
  logic signed [GW-1:0] sig_sum_r, sig_sum_nxt;

  // working registers
  logic [XW-1:0]        price_r, price_nxt;
  logic signed [MW-1:0] prod_a_r, prod_a_nxt;
  logic signed [MW-1:0] prod_b_r, prod_b_nxt;
  logic signed [OW-1:0] macd_r, macd_nxt;
  logic                 div_neg_r, div_neg_nxt;
  logic signed [OW-1:0] out_macd_r, out_macd_nxt;
  logic signed [OW-1:0] out_sig_r, out_sig_nxt;
  logic signed [OW-1:0] out_hist_r, out_hist_nxt;
  logic                 out_macd_ok_r, out_macd_ok_nxt;
  logic                 out_sig_ok_r, out_sig_ok_nxt;

  logic [CW-1:0]        fp, sp, gp, n, m, count_base;
  logic                 fast_seed, slow_seed, fast_ema, slow_ema;
  logic                 sig_seed, sig_ema, macd_ok, sig_ok;
  logic signed [DW-1:0] diff_f, diff_s, diff_g, op_a;
  logic [AW-1:0]        alpha_a;
  logic signed [MW-1:0] mul_a, mul_b, sh_a, sh_b;
  logic signed [OW-1:0] sig_sat;
  logic [QW-1:0]        div_dividend, div_quo, sig_mag;
  logic [PW-1:0]        div_divisor;
  logic                 div_done;
  logic signed [VW-1:0] quo_val;

  assign fp = {1'b0, macd_pkg::eff_period(fast_period_r)};
  assign sp = {1'b0, macd_pkg::eff_period(slow_period_r)};
  assign gp = {1'b0, macd_pkg::eff_period(signal_period_r)};
  assign n  = sample_count_r;
  assign m  = macd_count_r;

  assign fast_seed = n <= fp;
  assign slow_seed = n <= sp;
  assign fast_ema  = n > fp;
  assign slow_ema  = n > sp;
  assign macd_ok   = (n >= fp) && (n >= sp);
  assign sig_seed  = m <= gp;
  assign sig_ema   = m > gp;
  assign sig_ok    = macd_ok && (m >= gp);

  assign stat.fast_div = n == fp;
  assign stat.slow_div = n == sp;
  assign stat.macd_ok  = macd_ok;
  assign stat.sig_div  = m == gp;
  assign stat.div_done = div_done;

  // differences against the running averages
  assign diff_f = {{(DW-XW){1'b0}}, price_r} - {{(DW-VW){fast_avg_r[VW-1]}}, fast_avg_r};
  assign diff_s = {{(DW-XW){1'b0}}, price_r} - {{(DW-VW){slow_avg_r[VW-1]}}, slow_avg_r};
  assign diff_g = {{(DW-OW){macd_r[OW-1]}}, macd_r} - {{(DW-VW){sig_avg_r[VW-1]}}, sig_avg_r};

  assign op_a    = cmd.sig_stage ? diff_g : diff_f;
  assign alpha_a = cmd.sig_stage ? macd_pkg::eff_alpha(signal_alpha_r)
                                 : macd_pkg::eff_alpha(fast_alpha_r);

  assign mul_a = op_a * $signed({1'b0, alpha_a});
  assign mul_b = diff_s * $signed({1'b0, macd_pkg::eff_alpha(slow_alpha_r)});

  // floor division by the fraction scale
  assign sh_a = prod_a_r >>> macd_pkg::FRAC_W;
  assign sh_b = prod_b_r >>> macd_pkg::FRAC_W;

  assign sig_mag = sig_sum_r[GW-1] ? QW'(-sig_sum_r) : QW'(sig_sum_r);

  always_comb begin
    unique case (cmd.div_sel)
      macd_pkg::DIV_FAST: begin
        div_dividend = {{(QW-SW){1'b0}}, fast_sum_r};
        div_divisor  = macd_pkg::eff_period(fast_period_r);
      end
      macd_pkg::DIV_SLOW: begin
        div_dividend = {{(QW-SW){1'b0}}, slow_sum_r};
        div_divisor  = macd_pkg::eff_period(slow_period_r);
      end
      macd_pkg::DIV_SIG: begin
        div_dividend = sig_mag;
        div_divisor  = macd_pkg::eff_period(signal_period_r);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = PW'(1);
      end
    endcase
  end

  macd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign quo_val = div_neg_r ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

  assign sig_sat = macd_pkg::sat_out({{(DW-VW){sig_avg_r[VW-1]}}, sig_avg_r});

  assign count_base = in_restart ? '0 : sample_count_r;

  always_comb begin
    sample_count_nxt = sample_count_r;
    macd_count_nxt   = macd_count_r;
    fast_avg_nxt     = fast_avg_r;
    slow_avg_nxt     = slow_avg_r;
    sig_avg_nxt      = sig_avg_r;
    fast_sum_nxt     = fast_sum_r;
    slow_sum_nxt     = slow_sum_r;
    sig_sum_nxt      = sig_sum_r;
    price_nxt        = price_r;
    prod_a_nxt       = prod_a_r;
    prod_b_nxt       = prod_b_r;
    macd_nxt         = macd_r;
    div_neg_nxt      = div_neg_r;
    out_macd_nxt     = out_macd_r;
    out_sig_nxt      = out_sig_r;
    out_hist_nxt     = out_hist_r;
    out_macd_ok_nxt  = out_macd_ok_r;
    out_sig_ok_nxt   = out_sig_ok_r;

    if (cmd.load) begin
      price_nxt = in_price;
      if (in_restart) begin
        macd_count_nxt = '0;
        fast_avg_nxt   = '0;
        slow_avg_nxt   = '0;
        sig_avg_nxt    = '0;
        fast_sum_nxt   = '0;
        slow_sum_nxt   = '0;
        sig_sum_nxt    = '0;
      end
      sample_count_nxt = (count_base == '1) ? count_base : count_base + CW'(1);
    end

    if (cmd.price_stage) begin
      if (fast_seed) begin
        fast_sum_nxt = fast_sum_r + {{(SW-XW){1'b0}}, price_r};
      end
      if (slow_seed) begin
        slow_sum_nxt = slow_sum_r + {{(SW-XW){1'b0}}, price_r};
      end
      prod_a_nxt = mul_a;
      prod_b_nxt = mul_b;
    end

    if (cmd.ema_stage) begin
      if (fast_ema) begin
        fast_avg_nxt = fast_avg_r + sh_a[VW-1:0];
      end
      if (slow_ema) begin
        slow_avg_nxt = slow_avg_r + sh_b[VW-1:0];
      end
    end

    if (cmd.div_start) begin
      div_neg_nxt = (cmd.div_sel == macd_pkg::DIV_SIG) && sig_sum_r[GW-1];
    end
    if (cmd.wr_fast) begin
      fast_avg_nxt = quo_val;
    end
    if (cmd.wr_slow) begin
      slow_avg_nxt = quo_val;
    end
    if (cmd.wr_sig) begin
      sig_avg_nxt = quo_val;
    end

    if (cmd.macd_stage) begin
      macd_nxt = macd_pkg::sat_out({{(DW-VW){fast_avg_r[VW-1]}}, fast_avg_r}
                                   - {{(DW-VW){slow_avg_r[VW-1]}}, slow_avg_r});
      macd_count_nxt = (macd_count_r == '1) ? macd_count_r : macd_count_r + CW'(1);
    end

    if (cmd.sig_stage) begin
      if (sig_seed) begin
        sig_sum_nxt = sig_sum_r + {{(GW-OW){macd_r[OW-1]}}, macd_r};
      end else begin
        prod_a_nxt = mul_a;
      end
    end

    if (cmd.sema_stage && sig_ema) begin
      sig_avg_nxt = sig_avg_r + sh_a[VW-1:0];
    end

    if (cmd.out_load) begin
      out_macd_ok_nxt = macd_ok;
      out_sig_ok_nxt  = sig_ok;
      out_macd_nxt    = macd_ok ? macd_r : '0;
      out_sig_nxt     = sig_ok ? sig_sat : '0;
      out_hist_nxt    = sig_ok ? macd_pkg::sat_out({{(DW-OW){macd_r[OW-1]}}, macd_r}
                                                   - {{(DW-OW){sig_sat[OW-1]}}, sig_sat})
                               : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_period_r   <= macd_pkg::FAST_PERIOD_RST;
      slow_period_r   <= macd_pkg::SLOW_PERIOD_RST;
      signal_period_r <= macd_pkg::SIGNAL_PERIOD_RST;
      fast_alpha_r    <= macd_pkg::FAST_ALPHA_RST;
      slow_alpha_r    <= macd_pkg::SLOW_ALPHA_RST;
      signal_alpha_r  <= macd_pkg::SIGNAL_ALPHA_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        macd_pkg::CFG_FAST_PERIOD:   fast_period_r   <= cfg_data[PW-1:0];
        macd_pkg::CFG_SLOW_PERIOD:   slow_period_r   <= cfg_data[PW-1:0];
        macd_pkg::CFG_SIGNAL_PERIOD: signal_period_r <= cfg_data[PW-1:0];
        macd_pkg::CFG_FAST_ALPHA:    fast_alpha_r    <= cfg_data[AW-1:0];
        macd_pkg::CFG_SLOW_ALPHA:    slow_alpha_r    <= cfg_data[AW-1:0];
        macd_pkg::CFG_SIGNAL_ALPHA:  signal_alpha_r  <= cfg_data[AW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= '0;
      macd_count_r   <= '0;
      fast_avg_r     <= '0;
      slow_avg_r     <= '0;
      sig_avg_r      <= '0;
      fast_sum_r     <= '0;
      slow_sum_r     <= '0;
      sig_sum_r      <= '0;
    end else begin
      sample_count_r <= sample_count_nxt;
      macd_count_r   <= macd_count_nxt;
      fast_avg_r     <= fast_avg_nxt;
      slow_avg_r     <= slow_avg_nxt;
      sig_avg_r      <= sig_avg_nxt;
      fast_sum_r     <= fast_sum_nxt;
      slow_sum_r     <= slow_sum_nxt;
      sig_sum_r      <= sig_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r       <= price_nxt;
    prod_a_r      <= prod_a_nxt;
    prod_b_r      <= prod_b_nxt;
    macd_r        <= macd_nxt;
    div_neg_r     <= div_neg_nxt;
    out_macd_r    <= out_macd_nxt;
    out_sig_r     <= out_sig_nxt;
    out_hist_r    <= out_hist_nxt;
    out_macd_ok_r <= out_macd_ok_nxt;
    out_sig_ok_r  <= out_sig_ok_nxt;
  end

  assign res_macd    = out_macd_r;
  assign res_signal  = out_sig_r;
  assign res_hist    = out_hist_r;
  assign res_macd_ok = out_macd_ok_r;
  assign res_sig_ok  = out_sig_ok_r;

endmodule

[hw/rtl/macd_ctrl.sv]
// macd controller: sequences one word through the datapath and owns the
// channel handshakes; depends on macd_pkg
module macd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  macd_pkg::macd_stat_t stat,
  output macd_pkg::macd_cmd_t  cmd
);

  macd_pkg::macd_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= macd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      macd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = macd_pkg::ST_PRICE;
        end
      end
      macd_pkg::ST_PRICE: begin
        cmd.price_stage = 1'b1;
        state_nxt       = macd_pkg::ST_EMA;
      end
      macd_pkg::ST_EMA: begin
        cmd.ema_stage = 1'b1;
        priority if (stat.fast_div) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = macd_pkg::DIV_FAST;
          state_nxt     = macd_pkg::ST_FWAIT;
        end else if (stat.slow_div) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = macd_pkg::DIV_SLOW;
          state_nxt     = macd_pkg::ST_SWAIT;
        end else if (stat.macd_ok) begin
          state_nxt = macd_pkg::ST_MACD;
        end else begin
          state_nxt = macd_pkg::ST_OUT;
        end
      end
      macd_pkg::ST_FWAIT: begin
        if (stat.div_done) begin
          cmd.wr_fast = 1'b1;
          priority if (stat.slow_div) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = macd_pkg::DIV_SLOW;
            state_nxt     = macd_pkg::ST_SWAIT;
          end else if (stat.macd_ok) begin
            state_nxt = macd_pkg::ST_MACD;
          end else begin
            state_nxt = macd_pkg::ST_OUT;
          end
        end
      end
      macd_pkg::ST_SWAIT: begin
        if (stat.div_done) begin
          cmd.wr_slow = 1'b1;
          state_nxt   = stat.macd_ok ? macd_pkg::ST_MACD : macd_pkg::ST_OUT;
        end
      end
      macd_pkg::ST_MACD: begin
        cmd.macd_stage = 1'b1;
        state_nxt      = macd_pkg::ST_SIG;
      end
      macd_pkg::ST_SIG: begin
        cmd.sig_stage = 1'b1;
        state_nxt     = macd_pkg::ST_SEMA;
      end
      macd_pkg::ST_SEMA: begin
        cmd.sema_stage = 1'b1;
        if (stat.sig_div) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = macd_pkg::DIV_SIG;
          state_nxt     = macd_pkg::ST_GWAIT;
        end else begin
          state_nxt = macd_pkg::ST_OUT;
        end
      end
      macd_pkg::ST_GWAIT: begin
        if (stat.div_done) begin
          cmd.wr_sig = 1'b1;
          state_nxt  = macd_pkg::ST_OUT;
        end
      end
      macd_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = macd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = macd_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[hw/rtl/macd_indicator_unit.sv]
// macd indicator unit: top level joining controller and datapath
// depends on macd_pkg, macd_if, macd_ctrl, macd_datapath and the macro header
//
// usage:
//   in_chan carries one price word (unsigned Q16.16) with a restart flag that
//   clears all averages before the word is used. out_chan returns one result
//   word per price: macd, signal and histogram (signed Q18.16, saturated) and
//   the two valid flags. cfg_we/cfg_index/cfg_data write the periods and the
//   smoothing factors; write them only while the unit is idle.
//   on acceptance the word passes the price and ema states, then the macd,
//   sig and sema states once the macd is valid, and the out state that loads
//   the output register; a word that completes the seed of the fast, slow or
//   signal average also waits on the bit-serial seed divider for each such
//   seed. one word is in flight at a time: a new word is taken only in idle.
//   the result sits in an output register; the next price word is taken
//   while a result still waits, and a stalled receiver holds off only the
//   completion of the following word.
//   reset: periods and factors return to 12, 26, 9 and 10082, 4855, 13107,
//   all averages and counts clear and no result is pending.
`include "macd_indicator_unit_macros.svh"

module macd_indicator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  macd_in_if.sink                            in_chan,
  macd_out_if.source                         out_chan,
  input  logic                               cfg_we,
  input  logic [macd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [macd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  macd_pkg::macd_cmd_t  cmd;
  macd_pkg::macd_stat_t stat;

  macd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  macd_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_price    (in_chan.price),
    .in_restart  (in_chan.restart),
    .cmd         (cmd),
    .stat        (stat),
    .res_macd    (out_chan.macd_value),
    .res_signal  (out_chan.signal_value),
    .res_hist    (out_chan.histogram_value),
    .res_macd_ok (out_chan.macd_valid),
    .res_sig_ok  (out_chan.signal_valid)
  );

  `MACD_ASSERT_NEXT(a_busy_after_accept, in_chan.valid && in_chan.ready, !in_chan.ready, "accepted a word while busy")
  `MACD_ASSERT_NOW(a_seed_write_on_done, cmd.wr_fast || cmd.wr_slow || cmd.wr_sig, stat.div_done, "seed written without a quotient")
  `MACD_ASSERT_NOW(a_signal_needs_macd, out_chan.valid && out_chan.signal_valid, out_chan.macd_valid, "signal valid without macd valid")
  `MACD_ASSERT_NOW(a_macd_zero_invalid, out_chan.valid && !out_chan.macd_valid, out_chan.macd_value == '0, "macd value not cleared while invalid")

endmodule
